// ===== hw/rtl/rc4d_pkg.sv =====
// Shared constants, codes and beat structures for the RC4-drop keystream cipher.
// No dependencies; used by rc4d_engine and rc4_drop_keystream_cipher.
package rc4d_pkg;

    // Table and byte geometry
    localparam int BYTE_W       = 8;
    localparam int TABLE_SIZE   = 256;
    localparam int TBL_AW       = $clog2(TABLE_SIZE);
    localparam int KEY_BYTES_DEF = 8;
    localparam int KEY_W        = 64;
    localparam int DISC_W       = 16;
    localparam logic [DISC_W-1:0] DISC_RESET = 16'd1024;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_COUNT = 1'b1;

    // Input action codes
    localparam logic ACT_RESTART   = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    // Result status codes
    localparam logic ST_OK         = 1'b0;
    localparam logic ST_NOT_KEYED  = 1'b1;

    // One input beat as seen by the engine
    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              status;
    } t_res;

endpackage

// ===== hw/rtl/rc4d_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module rc4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; a read of the address being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rc4d_engine.sv =====
// Sequencer for the RC4 key schedule, keystream discard and byte translation.
// Depends on rc4d_pkg and holds the permutation table in one rc4d_ram instance.
module rc4d_engine #(
    parameter int KEY_BYTES = rc4d_pkg::KEY_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  rc4d_pkg::t_cmd               i_cmd,
    input  logic [rc4d_pkg::KEY_W-1:0]   i_cipher_key,
    input  logic [rc4d_pkg::DISC_W-1:0]  i_discard_count,
    output logic                         o_res_valid,
    output rc4d_pkg::t_res               o_res,
    input  logic                         i_res_take
);

    localparam int BW  = rc4d_pkg::BYTE_W;
    localparam int AW  = rc4d_pkg::TBL_AW;
    localparam int DW  = rc4d_pkg::DISC_W;
    localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [AW-1:0]  LAST_ENTRY = AW'(rc4d_pkg::TABLE_SIZE - 1);
    localparam logic [KIW-1:0] LAST_KEY   = KIW'(KEY_BYTES - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_FILL  = 12'b0000_0000_0010,
        S_KRD_I = 12'b0000_0000_0100,
        S_KRD_J = 12'b0000_0000_1000,
        S_KWR_A = 12'b0000_0001_0000,
        S_KWR_B = 12'b0000_0010_0000,
        S_GRD_I = 12'b0000_0100_0000,
        S_GRD_J = 12'b0000_1000_0000,
        S_GWR_A = 12'b0001_0000_0000,
        S_GWR_B = 12'b0010_0000_0000,
        S_GKS   = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic            r_keyed, n_keyed;
    logic            r_disc, n_disc;
    logic [AW-1:0]   r_n, n_n;
    logic [AW-1:0]   r_i, n_i;
    logic [AW-1:0]   r_j, n_j;
    logic [KIW-1:0]  r_kp, n_kp;
    logic [DW-1:0]   r_cnt, n_cnt;
    logic [BW-1:0]   r_si, n_si;
    logic [BW-1:0]   r_sj, n_sj;
    logic            r_fwd, n_fwd;
    logic [BW-1:0]   r_data, n_data;
    rc4d_pkg::t_res  r_res, n_res;

    // Memory port signals
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [BW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [BW-1:0]   mem_rdata;

    logic [BW-1:0]   key_byte;
    logic [AW-1:0]   j_sum;
    logic [AW-1:0]   i_next;
    logic [AW-1:0]   ks_addr;
    logic [BW-1:0]   ks_byte;

    rc4d_ram #(
        .WIDTH (BW),
        .DEPTH (rc4d_pkg::TABLE_SIZE)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Datapath terms shared by the states below.
    assign key_byte = i_cipher_key[BW * r_kp +: BW];
    assign i_next   = r_i + AW'(1);
    assign ks_addr  = r_si + r_sj;
    assign ks_byte  = r_fwd ? r_si : mem_rdata;
    always_comb begin
        if (r_state == S_KRD_J) begin
            j_sum = r_j + mem_rdata + key_byte;
        end else begin
            j_sum = r_j + mem_rdata;
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    // Next-state and memory access control. Every read is issued in a state of its own after
    // the writes it depends on, except the keystream lookup, which forwards the swapped S[i].
    always_comb begin
        n_state   = r_state;
        n_keyed   = r_keyed;
        n_disc    = r_disc;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_kp      = r_kp;
        n_cnt     = r_cnt;
        n_si      = r_si;
        n_sj      = r_sj;
        n_fwd     = r_fwd;
        n_data    = r_data;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_n;
        mem_wdata = r_n;
        mem_raddr = r_n;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_data     = i_cmd.data;
                    n_res.last = i_cmd.last;
                    if (i_cmd.action == rc4d_pkg::ACT_RESTART) begin
                        n_n     = '0;
                        n_cnt   = i_discard_count;
                        n_state = S_FILL;
                    end else if (!r_keyed) begin
                        n_res.data   = '0;
                        n_res.status = rc4d_pkg::ST_NOT_KEYED;
                        n_state      = S_EMIT;
                    end else begin
                        n_disc  = 1'b0;
                        n_state = S_GRD_I;
                    end
                end
            end

            // Identity fill, one entry a cycle.
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = r_n;
                n_n       = r_n + AW'(1);
                if (r_n == LAST_ENTRY) begin
                    n_j     = '0;
                    n_kp    = '0;
                    n_state = S_KRD_I;
                end
            end

            // Key schedule: read S[n], then S[j], then write both halves of the swap.
            S_KRD_I: begin
                mem_raddr = r_n;
                n_state   = S_KRD_J;
            end

            S_KRD_J: begin
                n_si      = mem_rdata;
                n_j       = j_sum;
                mem_raddr = j_sum;
                n_kp      = (r_kp == LAST_KEY) ? '0 : r_kp + KIW'(1);
                n_state   = S_KWR_A;
            end

            S_KWR_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = mem_rdata;
                n_state   = S_KWR_B;
            end

            S_KWR_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                n_n       = r_n + AW'(1);
                if (r_n == LAST_ENTRY) begin
                    n_i = '0;
                    n_j = '0;
                    if (r_cnt == '0) begin
                        n_keyed = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_disc  = 1'b1;
                        n_state = S_GRD_I;
                    end
                end else begin
                    n_state = S_KRD_I;
                end
            end

            // Keystream generation: step i and read S[i].
            S_GRD_I: begin
                n_i       = i_next;
                mem_raddr = i_next;
                n_state   = S_GRD_J;
            end

            S_GRD_J: begin
                n_si      = mem_rdata;
                n_j       = j_sum;
                mem_raddr = j_sum;
                n_state   = S_GWR_A;
            end

            S_GWR_A: begin
                n_sj      = mem_rdata;
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = mem_rdata;
                n_state   = S_GWR_B;
            end

            // The lookup is issued with the second swap write; when it hits S[j] the
            // RAM would return the old value, so the new one is forwarded instead.
            S_GWR_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                mem_raddr = ks_addr;
                n_fwd     = (ks_addr == r_j);
                n_state   = S_GKS;
            end

            S_GKS: begin
                if (r_disc) begin
                    n_cnt = r_cnt - DW'(1);
                    if (r_cnt == DW'(1)) begin
                        n_keyed = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_GRD_I;
                    end
                end else begin
                    n_res.data   = r_data ^ ks_byte;
                    n_res.status = rc4d_pkg::ST_OK;
                    n_state      = S_EMIT;
                end
            end

            S_EMIT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_keyed <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_keyed <= n_keyed;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_disc <= n_disc;
        r_n    <= n_n;
        r_kp   <= n_kp;
        r_cnt  <= n_cnt;
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_fwd  <= n_fwd;
        r_data <= n_data;
        r_res  <= n_res;
    end

endmodule

// ===== hw/rtl/rc4_drop_keystream_cipher.sv =====
// RC4-drop keystream cipher. Translate beat: the engine runs 5 RAM steps and an emit step, then
// the result is registered in the output register; when not keyed, only the emit step is run.
// Restart beat: the table is filled, each key schedule entry is read and swapped, then
// discard_count keystream bytes are generated and dropped before the next beat is taken.
// One beat is in work at a time; the next is taken while a result waits in the output register.
// Synchronous active-low reset clears control state, sets discard_count to 1024 and key to 0.
module rc4_drop_keystream_cipher #(
    parameter int KEY_BYTES = rc4d_pkg::KEY_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [rc4d_pkg::BYTE_W-1:0]       i_data_in,
    input  logic                              i_message_end,
    // Output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rc4d_pkg::BYTE_W-1:0]       o_data_out,
    output logic                              o_message_last,
    output logic                              o_status,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rc4d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rc4d_pkg::KEY_W-1:0]        i_cfg_data
);

    logic [rc4d_pkg::KEY_W-1:0]  r_cipher_key;
    logic [rc4d_pkg::DISC_W-1:0] r_discard_count;
    logic                        r_out_valid;
    rc4d_pkg::t_res              r_out;

    rc4d_pkg::t_cmd cmd;
    rc4d_pkg::t_res eng_res;
    logic           eng_ready;
    logic           eng_res_valid;
    logic           res_take;

    assign cmd.action = i_action;
    assign cmd.data   = i_data_in;
    assign cmd.last   = i_message_end;

    // The output register frees up when empty or when its beat leaves this cycle.
    assign res_take   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !eng_ready;

    rc4d_engine #(
        .KEY_BYTES (KEY_BYTES)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_in_valid),
        .o_cmd_ready     (eng_ready),
        .i_cmd           (cmd),
        .i_cipher_key    (r_cipher_key),
        .i_discard_count (r_discard_count),
        .o_res_valid     (eng_res_valid),
        .o_res           (eng_res),
        .i_res_take      (res_take)
    );

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key    <= '0;
            r_discard_count <= rc4d_pkg::DISC_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rc4d_pkg::CFG_CIPHER_KEY: begin
                    r_cipher_key <= i_cfg_data;
                end
                rc4d_pkg::CFG_DISCARD_COUNT: begin
                    r_discard_count <= i_cfg_data[rc4d_pkg::DISC_W-1:0];
                end
                default: begin
                    r_cipher_key <= r_cipher_key;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= eng_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_out     = r_out.data;
    assign o_message_last = r_out.last;
    assign o_status       = r_out.status;

endmodule
